>>> rtl/e0kc_pkg.sv
// shared types, constants and combiner functions for the e0 keystream cipher
// no dependencies; imported by the core, the sequencer and the top level
package e0kc_pkg;

    // register lengths
    localparam int LEN_A = 25;
    localparam int LEN_B = 31;
    localparam int LEN_C = 33;
    localparam int LEN_D = 39;

    // initialization schedule
    localparam int INIT_CLOCKS  = 240;
    localparam int COLLECT_FROM = 111;
    localparam int COLLECT_BITS = 128;
    localparam int COLLECT_LAST = COLLECT_FROM + COLLECT_BITS - 1;
    localparam int SAVE_AT      = 238;
    localparam int CARRY_HOLD   = 39;

    // fixed seed bits at the bottom of the fourth load stream
    localparam logic [63:0] LD_D_SEED = 64'd7;

    // keystream bits per data byte
    localparam int RUN_BITS = 8;

    // sequencer counter width, holds up to INIT_CLOCKS - 1
    localparam int CNT_W = 8;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_IV_LOW   = 2'd2,
        CFG_IV_HIGH  = 2'd3
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_RELOAD,
        ST_RUN,
        ST_DONE
    } t_state;

    // per-cycle commands from the sequencer to the cipher datapath
    typedef struct packed {
        logic             start;
        logic             init;
        logic             hold;
        logic             save;
        logic             collect;
        logic             reload;
        logic             run;
        logic [CNT_W-1:0] cnt;
    } t_core_ctl;

    // summation combiner carry update: bits 3..2 current, 1..0 previous
    function automatic logic [3:0] carry_next(input logic [3:0] carry, input logic [3:0] x);
        logic [1:0] cur;
        logic [1:0] prev;
        logic [2:0] sum;
        logic [3:0] acc;
        logic [1:0] t;
        cur  = carry[3:2];
        prev = carry[1:0];
        sum  = {2'b00, x[0]} + {2'b00, x[1]} + {2'b00, x[2]} + {2'b00, x[3]};
        acc  = {1'b0, sum} + {2'b00, cur};
        t    = {prev[0], prev[0] ^ prev[1]};
        return {acc[2:1] ^ cur ^ t, cur};
    endfunction

    // keystream bit from the register outputs and the current carry
    function automatic logic key_bit(input logic [3:0] carry, input logic [3:0] x);
        return ^x ^ carry[2];
    endfunction

endpackage

>>> rtl/e0kc_core.sv
// cipher datapath: four bit-serial lfsrs, summation combiner, load streams
// and the keystream collection shift register; uses e0kc_pkg
module e0kc_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  e0kc_pkg::t_core_ctl   i_ctl,
    input  logic [63:0]           i_key_low,
    input  logic [63:0]           i_key_high,
    input  logic [63:0]           i_iv_low,
    input  logic [15:0]           i_iv_high,
    output logic                  o_key_bit
);
    import e0kc_pkg::*;

    logic [LEN_A-1:0] r_a;
    logic [LEN_B-1:0] r_b;
    logic [LEN_C-1:0] r_c;
    logic [LEN_D-1:0] r_d;
    logic [3:0]       r_carry;
    logic [3:0]       r_saved;
    logic             r_pending;
    logic [63:0]      r_ld_a;
    logic [63:0]      r_ld_b;
    logic [63:0]      r_ld_c;
    logic [63:0]      r_ld_d;
    logic [COLLECT_BITS-1:0] r_z;

    logic fb_a, fb_b, fb_c, fb_d;
    logic [LEN_A-1:0] sh_a, ld_in_a, rl_a;
    logic [LEN_B-1:0] sh_b, ld_in_b, rl_b;
    logic [LEN_C-1:0] sh_c, ld_in_c, rl_c;
    logic [LEN_D-1:0] sh_d, ld_in_d, rl_d;
    logic [3:0]  x, x_rl, carry_in;
    logic        n_key;
    logic [7:0]  kb [16];
    logic [7:0]  ivb [10];
    logic [63:0] ld_a, ld_b, ld_c, ld_d;
    logic [7:0]  zb [16];

    // place a byte at a bit position of a load stream
    function automatic logic [63:0] at(input logic [7:0] b, input int pos);
        return {56'd0, b} << pos;
    endfunction

    // one lfsr step: shift up, feedback into bit 0
    assign fb_a = r_a[24] ^ r_a[19] ^ r_a[11] ^ r_a[7];
    assign fb_b = r_b[30] ^ r_b[23] ^ r_b[15] ^ r_b[11];
    assign fb_c = r_c[32] ^ r_c[27] ^ r_c[23] ^ r_c[3];
    assign fb_d = r_d[38] ^ r_d[35] ^ r_d[27] ^ r_d[3];
    assign sh_a = {r_a[LEN_A-2:0], fb_a};
    assign sh_b = {r_b[LEN_B-2:0], fb_b};
    assign sh_c = {r_c[LEN_C-2:0], fb_c};
    assign sh_d = {r_d[LEN_D-2:0], fb_d};

    // combiner inputs after the shift
    assign x = {sh_d[31], sh_c[31], sh_b[23], sh_a[23]};

    // carry forced to zero at the start of initialization
    assign carry_in = (i_ctl.init && i_ctl.hold) ? 4'd0 : r_carry;
    assign n_key    = key_bit(carry_in, x);

    // while the register is still filling, the load bit replaces the feedback
    assign ld_in_a = {sh_a[LEN_A-1:1], (i_ctl.cnt < CNT_W'(LEN_A)) ?
                      r_ld_a[0] : (fb_a ^ r_ld_a[0])};
    assign ld_in_b = {sh_b[LEN_B-1:1], (i_ctl.cnt < CNT_W'(LEN_B)) ?
                      r_ld_b[0] : (fb_b ^ r_ld_b[0])};
    assign ld_in_c = {sh_c[LEN_C-1:1], (i_ctl.cnt < CNT_W'(LEN_C)) ?
                      r_ld_c[0] : (fb_c ^ r_ld_c[0])};
    assign ld_in_d = {sh_d[LEN_D-1:1], (i_ctl.cnt < CNT_W'(LEN_D)) ?
                      r_ld_d[0] : (fb_d ^ r_ld_d[0])};

    // key and iv bytes
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            kb[k]     = i_key_low[8*k +: 8];
            kb[k + 8] = i_key_high[8*k +: 8];
            ivb[k]    = i_iv_low[8*k +: 8];
        end
        ivb[8] = i_iv_high[7:0];
        ivb[9] = i_iv_high[15:8];
    end

    // serial load streams, overlapping fields ored together
    assign ld_a = {63'd0, ivb[9][0]} | at(kb[0], 1) | at(kb[4], 9) | at(kb[8], 17) |
                  at(kb[12], 25) | at(ivb[7], 33) | at(ivb[2], 41);
    assign ld_b = 64'd1 | at(ivb[6], 3) | at(kb[1], 7) | at(kb[5], 15) | at(kb[9], 23) |
                  at(kb[13], 31) | at(ivb[0], 39) | at(ivb[3], 47);
    assign ld_c = {57'd0, ivb[9][7:1]} | at(kb[2], 1) | at(kb[6], 9) | at(kb[10], 17) |
                  at(kb[14], 25) | at(ivb[8], 33) | at(ivb[4], 41);
    assign ld_d = LD_D_SEED | ({60'd0, ivb[6][7:4]} << 3) | at(kb[3], 7) |
                  at(kb[7], 15) | at(kb[11], 23) | at(kb[15], 31) | at(ivb[1], 39) |
                  at(ivb[5], 47);

    // reload of the registers from the collected keystream
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            zb[k] = r_z[8*k +: 8];
        end
    end
    assign rl_a = {zb[12][0], zb[8], zb[4], zb[0]};
    assign rl_b = {zb[12][7:1], zb[9], zb[5], zb[1]};
    assign rl_c = {zb[15][0], zb[13], zb[10], zb[6], zb[2]};
    assign rl_d = {zb[15][7:1], zb[14], zb[11], zb[7], zb[3]};
    assign x_rl = {rl_d[31], rl_c[31], rl_b[23], rl_a[23]};

    // lfsr and combiner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a       <= '0;
            r_b       <= '0;
            r_c       <= '0;
            r_d       <= '0;
            r_carry   <= '0;
            r_saved   <= '0;
            r_pending <= 1'b0;
        end else if (i_ctl.start) begin
            r_a       <= '0;
            r_b       <= '0;
            r_c       <= '0;
            r_d       <= '0;
            r_carry   <= '0;
            r_saved   <= '0;
            r_pending <= 1'b0;
        end else if (i_ctl.init) begin
            r_a       <= ld_in_a;
            r_b       <= ld_in_b;
            r_c       <= ld_in_c;
            r_d       <= ld_in_d;
            r_carry   <= carry_next(carry_in, x);
            r_pending <= n_key;
            if (i_ctl.save) begin
                r_saved <= r_carry;
            end
        end else if (i_ctl.reload) begin
            r_a       <= rl_a;
            r_b       <= rl_b;
            r_c       <= rl_c;
            r_d       <= rl_d;
            r_pending <= key_bit(r_carry, x_rl);
            r_carry   <= carry_next(r_saved, x_rl);
        end else if (i_ctl.run) begin
            r_a       <= sh_a;
            r_b       <= sh_b;
            r_c       <= sh_c;
            r_d       <= sh_d;
            r_carry   <= carry_next(r_carry, x);
            r_pending <= n_key;
        end
    end

    // load streams shift out one bit per init clock
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_ld_a <= ld_a;
            r_ld_b <= ld_b;
            r_ld_c <= ld_c;
            r_ld_d <= ld_d;
        end else if (i_ctl.init) begin
            r_ld_a <= r_ld_a >> 1;
            r_ld_b <= r_ld_b >> 1;
            r_ld_c <= r_ld_c >> 1;
            r_ld_d <= r_ld_d >> 1;
        end
    end

    // keystream collection, first bit ends up in bit 0
    always_ff @(posedge i_clk) begin
        if (i_ctl.init && i_ctl.collect) begin
            r_z <= {n_key, r_z[COLLECT_BITS-1:1]};
        end
    end

    assign o_key_bit = r_pending;

endmodule

>>> rtl/e0kc_ctrl.sv
// sequencer: runs initialization, reload and the eight keystream clocks
// of each byte, and hands the result to the output register; uses e0kc_pkg
module e0kc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_req,
    input  logic                  i_restart,
    input  logic                  i_out_free,
    output e0kc_pkg::t_core_ctl   o_ctl,
    output logic                  o_busy,
    output logic                  o_load_run,
    output logic                  o_load_done
);
    import e0kc_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_core_ctl        ctl;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        ctl         = '0;
        ctl.cnt     = r_cnt;
        o_load_run  = 1'b0;
        o_load_done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_req) begin
                    n_cnt = '0;
                    if (i_restart) begin
                        ctl.start = 1'b1;
                        n_state   = ST_INIT;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_INIT: begin
                ctl.init    = 1'b1;
                ctl.hold    = r_cnt < CNT_W'(CARRY_HOLD);
                ctl.save    = r_cnt == CNT_W'(SAVE_AT);
                ctl.collect = (r_cnt >= CNT_W'(COLLECT_FROM)) &&
                              (r_cnt <= CNT_W'(COLLECT_LAST));
                if (r_cnt == CNT_W'(INIT_CLOCKS - 1)) begin
                    n_state = ST_RELOAD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_RELOAD: begin
                ctl.reload = 1'b1;
                n_cnt      = '0;
                n_state    = ST_RUN;
            end
            ST_RUN: begin
                ctl.run = 1'b1;
                if (r_cnt == CNT_W'(RUN_BITS - 1)) begin
                    if (i_out_free) begin
                        o_load_run = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_load_done = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ctl  = ctl;
    assign o_busy = r_state != ST_IDLE;

endmodule

>>> rtl/e0_keystream_cipher_core.sv
// E0 keystream cipher core. Each byte is XORed with the next eight keystream
// bits, first bit in bit 0; while a byte runs, the cipher advances one clock per
// cycle, and the result is loaded with the last cipher clock of the byte, or
// later if the output register is still held. A byte with restart set first runs
// the initialization from the key and IV registers and then a reload. The result
// sits in an output register, so the next byte can be taken while it waits.
// Configuration writes are taken at any time after reset; the key and IV are
// latched when a restart begins, so a write applies at the next restart. Top
// level; uses e0kc_pkg, e0kc_ctrl and e0kc_core.
module e0_keystream_cipher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_in,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_data_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  e0kc_pkg::t_cfg_idx i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import e0kc_pkg::*;

    logic [63:0] r_key_low, r_key_high, r_iv_low;
    logic [15:0] r_iv_high;
    logic        r_cfg_ready;
    logic [7:0]  r_data, n_data;
    logic [7:0]  r_data_out;
    logic        r_out_valid;

    t_core_ctl ctl;
    logic      busy, load_run, load_done, in_req, out_free, key;

    assign in_req   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    e0kc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (in_req),
        .i_restart   (i_restart),
        .i_out_free  (out_free),
        .o_ctl       (ctl),
        .o_busy      (busy),
        .o_load_run  (load_run),
        .o_load_done (load_done)
    );

    e0kc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_key_low  (r_key_low),
        .i_key_high (r_key_high),
        .i_iv_low   (r_iv_low),
        .i_iv_high  (r_iv_high),
        .o_key_bit  (key)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low   <= '0;
            r_key_high  <= '0;
            r_iv_low    <= '0;
            r_iv_high   <= '0;
            r_cfg_ready <= 1'b0;
        end else begin
            r_cfg_ready <= 1'b1;
            if (i_cfg_valid && r_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                    CFG_IV_LOW:   r_iv_low   <= i_cfg_data;
                    CFG_IV_HIGH:  r_iv_high  <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // data byte shifts through, one keystream bit per cipher clock
    assign n_data = {key ^ r_data[0], r_data[7:1]};

    always_ff @(posedge i_clk) begin
        if (in_req) begin
            r_data <= i_data_in;
        end else if (ctl.run) begin
            r_data <= n_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (load_run) begin
            r_data_out <= n_data;
        end else if (load_done) begin
            r_data_out <= r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_run || load_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = busy || !r_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_cfg_ready = r_cfg_ready;

endmodule

>>> rtl/e0kc_checker.sv
// port-level checks for the e0 keystream cipher core, attached by bind
// depends only on the top level's ports
module e0kc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_restart,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_data_out
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // a waiting result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_data_out))
        else $error("result changed while stalled");

    // one request at a time: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while working");

    // a restart request is still busy when a plain byte would already be done
    a_restart_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_restart) |-> ##9 o_in_stall)
        else $error("restart finished too early");

endmodule

bind e0_keystream_cipher_core e0kc_checker u_e0kc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_restart   (i_restart),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_data_out  (o_data_out)
);
